[design/array_double_ended_queue_defines.svh]
// Assertion macros used by the deque datapath.
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ADQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ADQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/adq_pkg.sv]
`timescale 1ns / 1ps

package adq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 5;

  // request kinds
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_REAR  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_REAR   = 2'd3;

  // result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  // register index of capacity_in_use (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [DataW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] popped_value;
    logic [1:0]              status;
    logic                    now_empty;
    logic                    now_full;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // latch the request word
    logic exec;  // update pointers, touch at most one slot
    logic show;  // result cycle
  } cmd_t;

endpackage

[design/adq_ram.sv]
`timescale 1ns / 1ps

module adq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/adq_ctrl.sv]
`timescale 1ns / 1ps

module adq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output adq_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign cmd_o.load = start_i && (state_q == S_IDLE);
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.show = (state_q == S_RESP);

endmodule

[design/adq_dpath.sv]
`timescale 1ns / 1ps
`include "array_double_ended_queue_defines.svh"

module adq_dpath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  adq_pkg::cmd_t                cmd_i,
  input  adq_pkg::req_t                req_i,
  input  logic [adq_pkg::CapW-1:0]     cap_i,
  output adq_pkg::result_t             result_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = ((IW > adq_pkg::CapW) ? IW : adq_pkg::CapW) + 1;
  localparam logic [CW-1:0] MaxW = CW'(MAX_ENTRIES);

  adq_pkg::req_t req_q;

  logic [IW-1:0] front_q, front_d;
  logic [IW-1:0] rear_q, rear_d;
  logic          empty_q, empty_d;
  logic [1:0]    status_q, status_d;
  logic          full_q, full_d;
  logic          pop_ok_q, pop_ok_d;

  logic [CW-1:0] cap_w, last_w;
  logic          is_push, at_rear;
  logic          ram_en, ram_we;
  logic [IW-1:0] ram_addr;
  logic [adq_pkg::DataW-1:0] ram_rdata;

  // clamp capacity to 1..MAX_ENTRIES
  always_comb begin
    cap_w = {{(CW-adq_pkg::CapW){1'b0}}, cap_i};
    if (cap_i == '0) cap_w = CW'(1);
    if (cap_w > MaxW) cap_w = MaxW;
    last_w = cap_w - CW'(1);
  end

  assign is_push = !req_q.kind[1];
  assign at_rear = req_q.kind[0];

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    status_d = adq_pkg::ST_DONE;
    pop_ok_d = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = front_q;
    if (is_push) begin
      if (empty_q) begin
        front_d  = '0;
        rear_d   = '0;
        empty_d  = 1'b0;
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = '0;
      end else if (!at_rear) begin
        if (front_q == '0) begin
          status_d = adq_pkg::ST_REFUSED;
        end else begin
          front_d  = front_q - IW'(1);
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = front_q - IW'(1);
        end
      end else begin
        if ({{(CW-IW){1'b0}}, rear_q} >= last_w) begin
          status_d = adq_pkg::ST_REFUSED;
        end else begin
          rear_d   = rear_q + IW'(1);
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = rear_q + IW'(1);
        end
      end
    end else begin
      if (empty_q) begin
        status_d = adq_pkg::ST_EMPTY;
      end else begin
        pop_ok_d = 1'b1;
        ram_en   = 1'b1;
        ram_addr = at_rear ? rear_q : front_q;
        if (front_q == rear_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end else if (at_rear) begin
          rear_d = rear_q - IW'(1);
        end else begin
          front_d = front_q + IW'(1);
        end
      end
    end
    full_d = !empty_d && (front_d == '0) && ({{(CW-IW){1'b0}}, rear_d} >= last_w);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      rear_q   <= '0;
      empty_q  <= 1'b1;
      status_q <= adq_pkg::ST_DONE;
      full_q   <= 1'b0;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      rear_q   <= rear_d;
      empty_q  <= empty_d;
      status_q <= status_d;
      full_q   <= full_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  adq_ram #(
    .WIDTH(adq_pkg::DataW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en && cmd_i.exec),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(req_q.push_value),
    .rdata_o(ram_rdata)
  );

  // popped word comes straight from the RAM's read register
  assign result_o.popped_value = pop_ok_q ? ram_rdata : '1;
  assign result_o.status       = status_q;
  assign result_o.now_empty    = empty_q;
  assign result_o.now_full     = full_q;

  `ADQ_ASSERT_NOW(a_empty_ptrs, empty_q, (front_q == '0) && (rear_q == '0),
                  "empty deque with nonzero pointers")
  `ADQ_ASSERT_NOW(a_run_order, !empty_q, front_q <= rear_q,
                  "front index past rear index")
  `ADQ_ASSERT_NOW(a_empty_status, cmd_i.show && (status_q == adq_pkg::ST_EMPTY),
                  empty_q && !pop_ok_q, "empty pop reported on nonempty deque")
  `ADQ_ASSERT_NEXT(a_full_not_empty, cmd_i.exec && full_d, !empty_q,
                   "full flag raised on empty deque")

endmodule

[design/array_double_ended_queue.sv]
`timescale 1ns / 1ps
// Channel   Handshake                          Word
// request   start, taken when busy low         req_i (kind, push_value)
// result    done_o, one-cycle strobe           result_o (popped_value, status, flags)
// config    APB write, psel&penable&pwrite     pwdata[4:0] -> capacity_in_use
//
// A request is latched, then the pointers update with at most one slot RAM access,
// then the result is shown; only after that can the next start be taken.
// The single-port slot RAM with its registered read sets the middle step.
// Reset empties the deque and sets capacity to 16; slot contents are not cleared.
// The result cannot be stalled; done_o is high for exactly one cycle.

module array_double_ended_queue #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  adq_pkg::req_t          req_i,
  output logic                   done_o,
  output adq_pkg::result_t       result_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  adq_pkg::cmd_t cmd;
  logic [adq_pkg::CapW-1:0] cap_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= adq_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == adq_pkg::REG_CAPACITY)) begin
      cap_q <= pwdata[adq_pkg::CapW-1:0];
    end
  end

  assign prdata = (paddr[2] == adq_pkg::REG_CAPACITY) ?
                  {{(32-adq_pkg::CapW){1'b0}}, cap_q} : '0;

  adq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  adq_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .cap_i   (cap_q),
    .result_o(result_o)
  );

  assign done_o = cmd.show;

endmodule
